>>> src/four_neighbour_stencil_sum_unit_assert.svh
// Assertion macros used by the stencil sum unit checker
`ifndef FOUR_NEIGHBOUR_STENCIL_SUM_UNIT_ASSERT_SVH
`define FOUR_NEIGHBOUR_STENCIL_SUM_UNIT_ASSERT_SVH

// same-cycle implication
`define FNSS_ASSERT_IMPLY(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FNSS_ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/fnss_pkg.sv
// Shared constants, beat types and helpers of the stencil sum unit
package fnss_pkg;

  localparam int MAX_COLS   = 1024;
  localparam int MAX_ROWS   = 4096;
  localparam int DATA_WIDTH = 32;

  localparam int SAMPLE_W = 32;
  localparam int SUM_W    = 32;

  localparam int FRAME_ROWS_FIELD_W = 13;
  localparam int FRAME_COLS_FIELD_W = 11;
  localparam int CFG_DATA_W         = 13;
  localparam int CFG_IDX_W          = 2;

  localparam int ROWS_W = $clog2(MAX_ROWS + 1);
  localparam int COLS_W = $clog2(MAX_COLS + 1);
  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W  = $clog2(MAX_COLS);

  localparam int LINE_DEPTH = 2 * MAX_COLS;
  localparam int LINE_AW    = $clog2(LINE_DEPTH);
  localparam int LINE_W     = 2 * DATA_WIDTH;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = CFG_IDX_W'(1);

  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_DRAIN  = 1'b1;

  typedef logic [DATA_WIDTH-1:0] data_t;

  typedef struct packed {
    logic                       action;
    logic signed [SAMPLE_W-1:0] sample;
  } src_beat_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] neighbour_sum;
    logic                    row_end;
    logic                    frame_end;
  } res_beat_t;

  function automatic logic [ROWS_W-1:0] clamp_rows(input logic [FRAME_ROWS_FIELD_W-1:0] v);
    logic [ROWS_W-1:0] r;
    if (v == '0) begin
      r = ROWS_W'(1);
    end else if (int'(v) > MAX_ROWS) begin
      r = ROWS_W'(MAX_ROWS);
    end else begin
      r = ROWS_W'(v);
    end
    return r;
  endfunction

  function automatic logic [COLS_W-1:0] clamp_cols(input logic [FRAME_COLS_FIELD_W-1:0] v);
    logic [COLS_W-1:0] r;
    if (v == '0) begin
      r = COLS_W'(1);
    end else if (int'(v) > MAX_COLS) begin
      r = COLS_W'(MAX_COLS);
    end else begin
      r = COLS_W'(v);
    end
    return r;
  endfunction

  function automatic logic [LINE_AW-1:0] line_addr(input logic parity,
                                                   input logic [COL_W-1:0] col);
    logic [LINE_AW-1:0] base;
    base = parity ? LINE_AW'(MAX_COLS) : '0;
    return base + LINE_AW'(col);
  endfunction

endpackage

>>> src/fnss_ram.sv
// Generic single-write, dual-read synchronous RAM with registered read data
module fnss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  output logic [WIDTH-1:0]         rd_data_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

>>> src/four_neighbour_stencil_sum_unit.sv
// Four-neighbour stencil sum over a raster frame, top level
//
// Accepts one beat per clock unless src_stall holds it off, and delivers at
// most one result per beat, registered first in pend, then in res_beat. Results
// for row r are released by the samples of row r+1, column by column; those of
// the last row are released by drain beats after the final sample. Two row
// buffers live in one RAM of 2*MAX_COLS words with one write and two read
// ports: each word keeps a sample and its left neighbour, so one access gives
// the upper neighbour and one gives the right and the next left neighbour.
// The RAM is not cleared after reset; no result reads a word the current
// frame has not written. Writing frame_rows or frame_cols restarts the frame.
module four_neighbour_stencil_sum_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                src_valid,
  output logic                                src_stall,
  input  fnss_pkg::src_beat_t                 src_beat,
  output logic                                res_valid,
  input  logic                                res_stall,
  output fnss_pkg::res_beat_t                 res_beat,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fnss_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fnss_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import fnss_pkg::*;

  typedef struct packed {
    data_t below;
    logic  use_up;
    logic  use_left;
    logic  use_right;
    logic  row_end;
    logic  frame_end;
  } pend_t;

  logic [ROWS_W-1:0]  frame_rows;
  logic [COLS_W-1:0]  frame_cols;
  logic [ROW_W-1:0]   in_row, in_row_next, out_row, out_row_next;
  logic [COL_W-1:0]   in_col, in_col_next, out_col, out_col_next;
  logic               in_done, in_done_next;
  data_t              prev_sample;
  logic               pend_valid;
  pend_t              pend, pend_next;
  data_t              left_val;

  logic               cfg_wr, cfg_restart, accept, emit, store_wr, pend_adv;
  logic               row_end, frame_end;
  logic [COLS_W-1:0]  in_col_inc, out_col_inc;
  logic [ROWS_W-1:0]  in_row_inc, out_row_inc;
  data_t              sample_ext, sum;
  logic [LINE_AW-1:0] wr_addr, up_addr, right_addr;
  logic [LINE_W-1:0]  wr_word, up_word, right_word;

  assign cfg_ready   = 1'b1;
  assign cfg_wr      = cfg_valid && cfg_ready;
  assign cfg_restart = cfg_wr && (cfg_index inside {REG_FRAME_ROWS, REG_FRAME_COLS});

  assign pend_adv  = !res_valid || !res_stall;
  assign src_stall = pend_valid && !pend_adv;
  assign accept    = src_valid && !src_stall;

  assign sample_ext  = DATA_WIDTH'(src_beat.sample);
  assign in_col_inc  = COLS_W'(in_col) + COLS_W'(1);
  assign in_row_inc  = ROWS_W'(in_row) + ROWS_W'(1);
  assign out_col_inc = COLS_W'(out_col) + COLS_W'(1);
  assign out_row_inc = ROWS_W'(out_row) + ROWS_W'(1);
  assign row_end     = (out_col_inc == frame_cols);
  assign frame_end   = row_end && (out_row_inc == frame_rows);

  assign emit     = (src_beat.action == ACT_DRAIN) ? in_done : (!in_done && in_row != '0);
  assign store_wr = accept && (src_beat.action == ACT_SAMPLE) && !in_done;

  assign wr_addr    = line_addr(in_row[0], in_col);
  assign up_addr    = line_addr(!out_row[0], out_col);
  assign right_addr = line_addr(out_row[0], out_col_inc[COL_W-1:0]);
  assign wr_word    = {sample_ext, prev_sample};

  always_comb begin
    pend_next.below     = (src_beat.action == ACT_DRAIN) ? '0 : sample_ext;
    pend_next.use_up    = (out_row != '0);
    pend_next.use_left  = (out_col != '0);
    pend_next.use_right = !row_end;
    pend_next.row_end   = row_end;
    pend_next.frame_end = frame_end;
  end

  always_comb begin
    in_row_next  = in_row;
    in_col_next  = in_col;
    out_row_next = out_row;
    out_col_next = out_col;
    in_done_next = in_done;
    if (store_wr) begin
      if (in_col_inc == frame_cols) begin
        in_col_next = '0;
        if (in_row_inc == frame_rows) begin
          in_row_next  = '0;
          in_done_next = 1'b1;
        end else begin
          in_row_next = in_row_inc[ROW_W-1:0];
        end
      end else begin
        in_col_next = in_col_inc[COL_W-1:0];
      end
    end
    if (accept && emit) begin
      if (frame_end) begin
        in_row_next  = '0;
        in_col_next  = '0;
        out_row_next = '0;
        out_col_next = '0;
        in_done_next = 1'b0;
      end else if (row_end) begin
        out_col_next = '0;
        out_row_next = out_row_inc[ROW_W-1:0];
      end else begin
        out_col_next = out_col_inc[COL_W-1:0];
      end
    end
    if (cfg_restart) begin
      in_row_next  = '0;
      in_col_next  = '0;
      out_row_next = '0;
      out_col_next = '0;
      in_done_next = 1'b0;
    end
  end

  always_comb begin
    sum = pend.below;
    if (pend.use_up) begin
      sum = sum + up_word[LINE_W-1 -: DATA_WIDTH];
    end
    if (pend.use_left) begin
      sum = sum + left_val;
    end
    if (pend.use_right) begin
      sum = sum + right_word[LINE_W-1 -: DATA_WIDTH];
    end
  end

  fnss_ram #(
    .WIDTH (LINE_W),
    .DEPTH (LINE_DEPTH)
  ) u_line_ram (
    .clk       (clk),
    .wr_en     (store_wr),
    .wr_addr   (wr_addr),
    .wr_data   (wr_word),
    .rd_en     (!src_stall),
    .rd_addr_a (up_addr),
    .rd_data_a (up_word),
    .rd_addr_b (right_addr),
    .rd_data_b (right_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_rows <= ROWS_W'(1);
      frame_cols <= COLS_W'(1);
      in_row     <= '0;
      in_col     <= '0;
      out_row    <= '0;
      out_col    <= '0;
      in_done    <= 1'b0;
      pend_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_index)
          REG_FRAME_ROWS: frame_rows <= clamp_rows(cfg_data[FRAME_ROWS_FIELD_W-1:0]);
          REG_FRAME_COLS: frame_cols <= clamp_cols(cfg_data[FRAME_COLS_FIELD_W-1:0]);
          default: ;
        endcase
      end
      in_row  <= in_row_next;
      in_col  <= in_col_next;
      out_row <= out_row_next;
      out_col <= out_col_next;
      in_done <= in_done_next;
      if (!src_stall) begin
        pend_valid <= accept && emit;
      end
      if (pend_adv) begin
        res_valid <= pend_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (store_wr) begin
      prev_sample <= sample_ext;
    end
    if (!src_stall) begin
      pend <= pend_next;
    end
    if (pend_adv && pend_valid) begin
      res_beat.neighbour_sum <= SUM_W'(sum);
      res_beat.row_end       <= pend.row_end;
      res_beat.frame_end     <= pend.frame_end;
      left_val               <= right_word[DATA_WIDTH-1:0];
    end
  end

endmodule

>>> src/fnss_checker.sv
// Port-level checker for the stencil sum unit, bound to the top level
`include "four_neighbour_stencil_sum_unit_assert.svh"

module fnss_checker (
  input logic                clk,
  input logic                rst,
  input logic                src_valid,
  input logic                src_stall,
  input logic                res_valid,
  input logic                res_stall,
  input fnss_pkg::res_beat_t res_beat
);
  import fnss_pkg::*;

  `FNSS_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && res_stall, res_valid && $stable(res_beat), "stalled result beat changed")
  `FNSS_ASSERT_IMPLY(a_frame_end_row_end, clk, rst, res_valid && res_beat.frame_end, res_beat.row_end, "frame end without row end")
  `FNSS_ASSERT_IMPLY(a_stall_cause, clk, rst, src_stall, res_valid && res_stall, "input stalled while result side free")
  `FNSS_ASSERT_IMPLY(a_result_latency, clk, rst, $rose(res_valid), $past(src_valid && !src_stall, 2), "result without input beat two cycles before")
  `FNSS_ASSERT_NEXT(a_reset_clears, clk, 1'b0, rst, !res_valid, "result valid after reset")

endmodule

bind four_neighbour_stencil_sum_unit fnss_checker u_fnss_checker (.*);

>>> verif/four_neighbour_stencil_sum_unit_tb.sv
// Self-checking testbench for the four-neighbour stencil sum unit
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fnss_pkg::*;

  localparam int LIMIT = 2_000_000;
  localparam int DRAIN_WAIT = 4;
  localparam int TAIL_WAIT = 8;
  localparam int RANDOM_ITEMS = 1300;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

  class neighbour_sum_scoreboard;
    logic [DATA_WIDTH-1:0] line_mem [LINE_DEPTH];
    int rows;
    int cols;
    int in_r;
    int in_c;
    int out_r;
    int out_c;
    bit in_done;
    res_beat_t sums_due [$];
    int errors;

    function new();
      foreach (line_mem[i]) line_mem[i] = '0;
      rows = 1;
      cols = 1;
      errors = 0;
      restart();
    endfunction

    function void restart();
      in_r = 0;
      in_c = 0;
      out_r = 0;
      out_c = 0;
      in_done = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      int v;
      if (idx == REG_FRAME_ROWS) begin
        v = int'(val[FRAME_ROWS_FIELD_W-1:0]);
        rows = (v < 1) ? 1 : ((v > MAX_ROWS) ? MAX_ROWS : v);
        restart();
      end else if (idx == REG_FRAME_COLS) begin
        v = int'(val[FRAME_COLS_FIELD_W-1:0]);
        cols = (v < 1) ? 1 : ((v > MAX_COLS) ? MAX_COLS : v);
        restart();
      end
    endfunction

    function void emit(logic [DATA_WIDTH-1:0] below);
      logic [DATA_WIDTH-1:0] s;
      res_beat_t r;
      s = below;
      if (out_r > 0) s += line_mem[((out_r - 1) % 2) * MAX_COLS + out_c];
      if (out_c > 0) s += line_mem[(out_r % 2) * MAX_COLS + out_c - 1];
      if (out_c + 1 < cols) s += line_mem[(out_r % 2) * MAX_COLS + out_c + 1];
      r.neighbour_sum = s[SUM_W-1:0];
      r.row_end = (out_c + 1 == cols);
      r.frame_end = r.row_end && (out_r + 1 == rows);
      sums_due.push_back(r);
      if (r.frame_end) begin
        restart();
      end else if (r.row_end) begin
        out_c = 0;
        out_r++;
      end else begin
        out_c++;
      end
    endfunction

    function void take_beat(src_beat_t b);
      if (b.action == ACT_DRAIN) begin
        if (in_done) emit('0);
      end else if (!in_done) begin
        if (in_r > 0) emit(b.sample);
        line_mem[(in_r % 2) * MAX_COLS + in_c] = b.sample;
        in_c++;
        if (in_c >= cols) begin
          in_c = 0;
          in_r++;
          if (in_r >= rows) begin
            in_r = 0;
            in_done = 1;
          end
        end
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("[%0t] ERROR %s", $time, msg);
    endtask

    task check_sum(res_beat_t got);
      res_beat_t want;
      if (sums_due.size() == 0) begin
        report($sformatf("result with none expected: sum %0d row_end %0b frame_end %0b",
                         got.neighbour_sum, got.row_end, got.frame_end));
      end else begin
        want = sums_due.pop_front();
        if (got.neighbour_sum !== want.neighbour_sum)
          report($sformatf("neighbour_sum %0d, expected %0d",
                           got.neighbour_sum, want.neighbour_sum));
        if (got.row_end !== want.row_end)
          report($sformatf("row_end %0b, expected %0b", got.row_end, want.row_end));
        if (got.frame_end !== want.frame_end)
          report($sformatf("frame_end %0b, expected %0b", got.frame_end, want.frame_end));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic src_valid = 1'b0;
  logic src_stall;
  src_beat_t src_beat = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_beat_t res_beat;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  neighbour_sum_scoreboard sb = new();
  int cycles = 0;
  int stall_left = 0;
  bit src_calm = 0;
  bit res_calm = 0;
  int rand_items = 0;

  four_neighbour_stencil_sum_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_beat  (src_beat),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_beat  (res_beat),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(9, 16);
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample(int edge_pct);
    if ($urandom_range(0, 99) >= edge_pct) return $urandom;
    case ($urandom_range(0, 4))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0000;
      default: return 32'h0000_0001;
    endcase
  endfunction

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("four_neighbour_stencil_sum_unit: mismatch");
      $finish;
    end else begin
      if (!rst) begin
        if (src_valid && !src_stall) sb.take_beat(src_beat);
        if (res_valid && !res_stall) sb.check_sum(res_beat);
      end
      if (stall_left > 0) begin
        res_stall <= 1'b1;
        stall_left--;
      end else begin
        res_stall <= 1'b0;
        if (!res_calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  task send_beat(logic act, logic [SAMPLE_W-1:0] val);
    src_beat_t b;
    int gap;
    b.action = act;
    b.sample = val;
    src_valid <= 1'b1;
    src_beat <= b;
    do @(posedge clk); while (src_stall);
    gap = src_calm ? 0 : pick_gap();
    if (gap > 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off until every expected sum is out and the pipeline has drained
  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    src_valid <= 1'b0;
    do @(posedge clk); while (sb.sums_due.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    cfg_valid <= 1'b0;
  endtask

  task run_frame(int edge_pct, int noise_pct, int abort_at, output int sent);
    int n;
    int c;
    n = sb.rows * sb.cols;
    c = sb.cols;
    sent = 0;
    for (int i = 0; i < n; i++) begin
      if (i == abort_at) return;
      if ($urandom_range(0, 99) < noise_pct) send_beat(ACT_DRAIN, $urandom);
      send_beat(ACT_SAMPLE, pick_sample(edge_pct));
      sent++;
    end
    for (int j = 0; j < c; j++) begin
      if ($urandom_range(0, 99) < noise_pct) send_beat(ACT_SAMPLE, $urandom);
      send_beat(ACT_DRAIN, $urandom);
      sent++;
    end
  endtask

  initial begin
    int sent;
    int nr;
    int nc;
    int frames;
    int abort_at;
    logic [CFG_DATA_W-1:0] rows_val;
    logic [CFG_DATA_W-1:0] cols_val;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_beat(ACT_DRAIN, $urandom);
    send_beat(ACT_SAMPLE, 32'h7fff_ffff);
    send_beat(ACT_SAMPLE, 32'h8000_0000);
    send_beat(ACT_DRAIN, $urandom);

    write_reg(REG_FRAME_ROWS, CFG_DATA_W'(3));
    write_reg(REG_FRAME_COLS, CFG_DATA_W'(3));
    run_frame(100, 30, -1, sent);

    write_reg(REG_FRAME_ROWS, CFG_DATA_W'(0));
    write_reg(REG_FRAME_COLS, CFG_DATA_W'(5));
    run_frame(50, 0, -1, sent);

    write_reg(REG_FRAME_COLS, CFG_DATA_W'(4));
    write_reg(REG_FRAME_ROWS, CFG_DATA_W'(3));
    run_frame(50, 0, 6, sent);
    write_reg(REG_FRAME_ROWS, CFG_DATA_W'(2));
    run_frame(50, 0, -1, sent);

    write_reg(REG_FRAME_ROWS, 13'h1fff);
    write_reg(REG_FRAME_COLS, 13'h1fff);
    run_frame(50, 0, 5, sent);
    write_reg(REG_SPARE_A, CFG_DATA_W'($urandom));
    write_reg(REG_SPARE_B, CFG_DATA_W'($urandom));
    run_frame(50, 0, 5, sent);

    src_calm = 1;
    res_calm = 1;
    write_reg(REG_FRAME_ROWS, CFG_DATA_W'(MAX_ROWS));
    write_reg(REG_FRAME_COLS, CFG_DATA_W'(1));
    run_frame(20, 0, 64, sent);
    write_reg(REG_FRAME_ROWS, CFG_DATA_W'(2));
    write_reg(REG_FRAME_COLS, CFG_DATA_W'(MAX_COLS));
    src_calm = 0;
    res_calm = 0;
    run_frame(20, 0, 40, sent);

    write_reg(REG_FRAME_ROWS, CFG_DATA_W'(MAX_ROWS + 1));
    write_reg(REG_FRAME_COLS, CFG_DATA_W'(2048));
    run_frame(20, 0, 3, sent);

    while (rand_items < RANDOM_ITEMS) begin
      src_calm = ($urandom_range(0, 4) == 0);
      res_calm = ($urandom_range(0, 4) == 0);
      nr = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
      nc = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 64) : $urandom_range(1, 6);
      rows_val = CFG_DATA_W'(nr);
      cols_val = CFG_DATA_W'(nc);
      if ($urandom_range(0, 19) == 0) rows_val = CFG_DATA_W'($urandom_range(MAX_ROWS + 1, 8191));
      if ($urandom_range(0, 19) == 0) rows_val = '0;
      if ($urandom_range(0, 3) == 0)
        cols_val[CFG_DATA_W-1:FRAME_COLS_FIELD_W] =
          (CFG_DATA_W - FRAME_COLS_FIELD_W)'($urandom);
      if ($urandom_range(0, 1) == 0) begin
        write_reg(REG_FRAME_ROWS, rows_val);
        write_reg(REG_FRAME_COLS, cols_val);
      end else begin
        write_reg(REG_FRAME_COLS, cols_val);
        write_reg(REG_FRAME_ROWS, rows_val);
      end
      if ($urandom_range(0, 9) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, CFG_DATA_W'($urandom));
      frames = $urandom_range(1, 3);
      for (int f = 0; f < frames; f++) begin
        abort_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, sb.rows * sb.cols - 1) : -1;
        run_frame(10, 8, abort_at, sent);
        rand_items += sent;
        if (abort_at >= 0) break;
      end
    end

    src_valid <= 1'b0;
    do @(posedge clk); while (sb.sums_due.size() != 0);
    repeat (TAIL_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.sums_due.size() == 0) begin
      $display("four_neighbour_stencil_sum_unit: match");
    end else begin
      $display("four_neighbour_stencil_sum_unit: mismatch");
    end
    $finish;
  end
endmodule
